// File: hw/rtl/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg
// Shared types and codes for the selective-repeat window block.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int unsigned SEQ_W     = 5;
    localparam int unsigned OUTC_W    = 32;
    localparam int unsigned SLOT_W    = 4;

    localparam logic [2:0] SEQ_BITS_MIN   = 3'd1;
    localparam logic [2:0] SEQ_BITS_MAX   = 3'd5;
    localparam logic [2:0] SEQ_BITS_RESET = 3'd3;

    // channel outcome per slot
    localparam logic [1:0] OC_ACK_OK   = 2'd0;
    localparam logic [1:0] OC_ACK_LOST = 2'd1;
    localparam logic [1:0] OC_DAMAGED  = 2'd2;
    localparam logic [1:0] OC_LOST     = 2'd3;

    typedef enum logic [2:0] {
        EV_NEW_OK   = 3'd0,
        EV_NEW_LOST = 3'd1,
        EV_DUP_OK   = 3'd2,
        EV_DUP_LOST = 3'd3,
        EV_NAK      = 3'd4,
        EV_LOST     = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SLIDE = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stall;
        logic idx_last;
        logic head_acked;
    } t_sts;

endpackage

// File: hw/rtl/srw_in_if.sv
// ----------------------------------------------------------------------------
// srw_in_if
// Input channel: one round of channel outcomes per transfer.
// ----------------------------------------------------------------------------
interface srw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] slot_outcomes;

    modport source (output valid, output slot_outcomes, input ready);
    modport sink   (input valid, input slot_outcomes, output ready);
endinterface

// File: hw/rtl/srw_out_if.sv
// ----------------------------------------------------------------------------
// srw_out_if
// Output channel: one transmitted frame per transfer.
// ----------------------------------------------------------------------------
interface srw_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot_index;
    logic [4:0] seq_number;
    logic [2:0] event_res;
    logic       last;

    modport source (output valid, output slot_index, output seq_number,
                    output event_res, output last, input ready);
    modport sink   (input valid, input slot_index, input seq_number,
                    input event_res, input last, output ready);
endinterface

// File: hw/rtl/srw_ctrl.sv
// ----------------------------------------------------------------------------
// srw_ctrl
// Round sequencer: accept, walk the slots, slide the window.
// ----------------------------------------------------------------------------
module srw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srw_pkg::t_sts  i_sts,
    output srw_pkg::t_cmd  o_cmd
);

    srw_pkg::t_state r_state;
    srw_pkg::t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            srw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = srw_pkg::S_SCAN;
                end
            end
            srw_pkg::S_SCAN: begin
                if (!i_sts.stall) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = srw_pkg::S_SLIDE;
                    end
                end
            end
            srw_pkg::S_SLIDE: begin
                if (i_sts.head_acked) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    n_state = srw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/srw_dp.sv
// ----------------------------------------------------------------------------
// srw_dp
// Window storage, receiver match, slide shifter and output register.
// ----------------------------------------------------------------------------
module srw_dp #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_data,
    input  logic [31:0]             i_outcomes,
    input  srw_pkg::t_cmd           i_cmd,
    output srw_pkg::t_sts           o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [3:0]              o_slot_index,
    output logic [4:0]              o_seq_number,
    output logic [2:0]              o_event_res,
    output logic                    o_last
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    function automatic logic [CW-1:0] f_window(input logic [2:0] sb);
        logic [4:0] pow;
        pow = 5'd1 << (sb - 3'd1);
        return (MAX_WINDOW < int'(pow)) ? CW'(MAX_WINDOW) : CW'(pow);
    endfunction

    function automatic logic [4:0] f_mask(input logic [2:0] sb);
        return 5'((6'd1 << sb) - 6'd1);
    endfunction

    logic [2:0]              r_seq_bits;
    logic [4:0]              r_tx_seq [MAX_WINDOW];
    logic [4:0]              r_rx_exp [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   r_acked;
    logic [4:0]              r_tx_next;
    logic [4:0]              r_rx_next;
    logic [31:0]             r_outc;
    logic [IW-1:0]           r_idx;
    logic                    r_out_valid;
    logic [3:0]              r_o_slot;
    logic [4:0]              r_o_seq;
    logic [2:0]              r_o_ev;
    logic                    r_o_last;

    logic [2:0]              init_sb;
    logic [4:0]              init_mask;
    logic [4:0]              init_next;
    logic [4:0]              mask;
    logic [CW-1:0]           win;
    logic [4:0]              cur_seq;
    logic                    cur_pending;
    logic [1:0]              cur_oc;
    logic [MAX_WINDOW-1:0]   match;
    logic [MAX_WINDOW-1:0]   first;
    logic [MAX_WINDOW-1:0]   later;
    logic                    found;
    logic                    is_last;
    srw_pkg::t_event         ev;
    logic [4:0]              tx_up  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   ack_up;

    // clamp of the written size; reset picks the default
    always_comb begin
        if (!i_rst_n) begin
            init_sb = srw_pkg::SEQ_BITS_RESET;
        end else if (i_cfg_data < srw_pkg::SEQ_BITS_MIN) begin
            init_sb = srw_pkg::SEQ_BITS_MIN;
        end else if (i_cfg_data > srw_pkg::SEQ_BITS_MAX) begin
            init_sb = srw_pkg::SEQ_BITS_MAX;
        end else begin
            init_sb = i_cfg_data;
        end
    end

    assign init_mask = f_mask(init_sb);
    assign init_next = 5'(f_window(init_sb)) & init_mask;
    assign mask      = f_mask(r_seq_bits);
    assign win       = f_window(r_seq_bits);

    assign cur_seq     = r_tx_seq[r_idx];
    assign cur_pending = !r_acked[r_idx];
    assign cur_oc      = r_outc[{4'(r_idx), 1'b0} +: 2];

    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            match[j] = (j < int'(win)) && (r_rx_exp[j] == cur_seq);
            later[j] = (j > int'(r_idx)) && (j < int'(win)) && !r_acked[j];
        end
    end

    // lowest matching receiver slot, one-hot
    assign first   = match & (~match + MAX_WINDOW'(1));
    assign found   = |match;
    assign is_last = ~|later;

    always_comb begin
        case (cur_oc)
            srw_pkg::OC_ACK_OK:   ev = found ? srw_pkg::EV_NEW_OK   : srw_pkg::EV_DUP_OK;
            srw_pkg::OC_ACK_LOST: ev = found ? srw_pkg::EV_NEW_LOST : srw_pkg::EV_DUP_LOST;
            srw_pkg::OC_DAMAGED:  ev = srw_pkg::EV_NAK;
            default:              ev = srw_pkg::EV_LOST;
        endcase
    end

    // neighbour taps for the one-place slide
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_up
        if (k < MAX_WINDOW - 1) begin : g_mid
            assign tx_up[k]  = r_tx_seq[k+1];
            assign ack_up[k] = r_acked[k+1];
        end else begin : g_top
            assign tx_up[k]  = r_tx_seq[k];
            assign ack_up[k] = r_acked[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_seq_bits <= init_sb;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_tx_seq[i] <= 5'(i) & init_mask;
                r_rx_exp[i] <= 5'(i) & init_mask;
                r_acked[i]  <= 1'b0;
            end
            r_tx_next <= init_next;
            r_rx_next <= init_next;
        end else begin
            if (i_cmd.load) begin
                r_outc <= i_outcomes;
                r_idx  <= '0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + IW'(1);
                if (cur_pending) begin
                    if (cur_oc == srw_pkg::OC_ACK_OK || cur_oc == srw_pkg::OC_ACK_LOST) begin
                        if (found) begin
                            for (int j = 0; j < MAX_WINDOW; j++) begin
                                if (first[j]) begin
                                    r_rx_exp[j] <= r_rx_next;
                                end
                            end
                            r_rx_next <= (r_rx_next + 5'd1) & mask;
                        end
                        r_acked[r_idx] <= (cur_oc == srw_pkg::OC_ACK_OK);
                    end
                    r_o_slot <= 4'(r_idx);
                    r_o_seq  <= cur_seq;
                    r_o_ev   <= ev;
                    r_o_last <= is_last;
                end
            end
            if (i_cmd.shift) begin
                for (int k = 0; k < MAX_WINDOW; k++) begin
                    if ((k + 1) < int'(win)) begin
                        r_tx_seq[k] <= tx_up[k];
                        r_acked[k]  <= ack_up[k];
                    end else if ((k + 1) == int'(win)) begin
                        r_tx_seq[k] <= r_tx_next;
                        r_acked[k]  <= 1'b0;
                    end
                end
                r_tx_next <= (r_tx_next + 5'd1) & mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && cur_pending) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.stall      = cur_pending && r_out_valid && !i_out_ready;
    assign o_sts.idx_last   = (CW'(r_idx) + CW'(1)) == win;
    assign o_sts.head_acked = r_acked[0];

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_o_slot;
    assign o_seq_number = r_o_seq;
    assign o_event_res  = r_o_ev;
    assign o_last       = r_o_last;

endmodule

// File: hw/rtl/selective_repeat_window_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_window_top: selective-repeat ARQ window, one round per input
// Round of window w: scan steps through the w slots (held while the output
// register is held), then slide drops each acknowledged head slot, then idle.
// A new input is taken only once the round has returned to idle.
// Sync reset: seq_bits 3, window 4; a seq_bits write reinitialises the windows.
// ----------------------------------------------------------------------------
module selective_repeat_window_top #(
    parameter int MAX_WINDOW = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_data,
    srw_in_if.sink       i_in,
    srw_out_if.source    o_out
);

    // command and status between sequencer and datapath
    srw_pkg::t_cmd cmd;
    srw_pkg::t_sts sts;
    logic          in_ready;

    // Sequencer: idle takes one transfer, scan walks the slots one per cycle
    // (held while a pending slot's result cannot enter the output register),
    // slide drops one acknowledged head slot per cycle.
    srw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: sender and receiver windows in flops, a parallel match over
    // the receiver window, and the output register that parts the two sides.
    srw_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_outcomes   (i_in.slot_outcomes),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_slot_index (o_out.slot_index),
        .o_seq_number (o_out.seq_number),
        .o_event_res  (o_out.event_res),
        .o_last       (o_out.last)
    );

    assign i_in.ready = in_ready;

    // an input transfer starts a round, so no second one follows at once
    a_one_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken twice in a row");

    // a result is only produced while a round is under way
    a_result_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result raised outside a round");

endmodule
